[rtl/bhpq_pkg.sv]
// ----------------------------------------------------------------------------
// bhpq_pkg: shared types and constants for the binary heap priority queue
// Capacity, widths, status codes and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_BITS  = 32;
    localparam int PAY_BITS  = 32;
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int ENT_BITS  = KEY_BITS + PAY_BITS;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // what the controller asks of the datapath
    typedef struct packed {
        logic load;        // capture input word
        logic reject;      // insert into full or extract from empty
        logic up_init;     // sift up: start at end slot
        logic up_step;     // sift up: parent data back, decide
        logic dn_init;     // extract: read root (port a) and last (port b)
        logic dn_root;     // extract: latch root, last entry becomes moving entry
        logic dn_step;     // sift down: children back, decide
        logic done;        // write final entry, build result
    } bhpq_cmd_t;

    typedef struct packed {
        logic is_extract;
        logic empty;
        logic full;
        logic up_stop;     // sift up finished
        logic dn_stop;     // sift down finished
    } bhpq_stat_t;

    function automatic logic ranks_above(input logic signed [KEY_BITS-1:0] a,
                                         input logic signed [KEY_BITS-1:0] b,
                                         input logic max_mode);
        ranks_above = max_mode ? (a > b) : (a < b);
    endfunction

endpackage

[rtl/binary_heap_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_top: 64-entry binary heap priority queue
//
//   channel | signals                                  | direction
//   input   | valid, stall, op, key, payload           | in (stall out)
//   output  | out_valid, out_stall, status, top_key,   | out (stall in)
//           | top_payload, fill                        |
//   config  | cfg_valid, cfg_ready, cfg_data           | in (ready out)
//
// One item at a time. An entry moves at most 6 levels on insert and at most 5
// on extract; a rejected insert or extract moves none. Each level takes a
// wait for the registered read of the two heap RAM copies, then a compare
// and move.
// Reset clears the fill count and sets max mode; RAM contents are not cleared.
// Input is stalled while busy or while a result word waits on a stalled output.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  valid,
    output logic                                  stall,
    input  logic                                  op,
    input  logic signed [bhpq_pkg::KEY_BITS-1:0]  key,
    input  logic [bhpq_pkg::PAY_BITS-1:0]         payload,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [1:0]                            status,
    output logic signed [bhpq_pkg::KEY_BITS-1:0]  top_key,
    output logic [bhpq_pkg::PAY_BITS-1:0]         top_payload,
    output logic [bhpq_pkg::CNT_BITS-1:0]         fill,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_data
);

    bhpq_pkg::bhpq_cmd_t  cmd;
    bhpq_pkg::bhpq_stat_t stat;
    logic                 busy;
    logic                 max_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_mode_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_mode_reg <= cfg_data;
        end
    end

    bhpq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(valid), .in_stall(stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat),
        .cmd(cmd), .busy(busy)
    );

    bhpq_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .max_mode(max_mode_reg), .cmd(cmd), .stat(stat),
        .in_op(op), .in_key(key), .in_payload(payload),
        .res_status(status), .res_key(top_key), .res_payload(top_payload),
        .res_fill(fill)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> stall)
        else $error("input accepted while busy");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill <= bhpq_pkg::CNT_BITS'(bhpq_pkg::CAPACITY)))
        else $error("fill beyond capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != bhpq_pkg::ST_OK) |-> (top_key == '0 && top_payload == '0))
        else $error("failed op returned data");

endmodule

[rtl/bhpq_ram.sv]
// ----------------------------------------------------------------------------
// bhpq_ram: generic simple RAM, one write port, one registered read port
// ----------------------------------------------------------------------------
module bhpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/bhpq_datapath.sv]
// ----------------------------------------------------------------------------
// bhpq_datapath: heap storage, moving entry, position and count registers
// Two RAM copies give two reads a cycle (both children); writes go to both.
// ----------------------------------------------------------------------------
module bhpq_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              max_mode,
    input  bhpq_pkg::bhpq_cmd_t               cmd,
    output bhpq_pkg::bhpq_stat_t              stat,
    input  logic                              in_op,
    input  logic signed [bhpq_pkg::KEY_BITS-1:0] in_key,
    input  logic [bhpq_pkg::PAY_BITS-1:0]     in_payload,
    output logic [1:0]                        res_status,
    output logic signed [bhpq_pkg::KEY_BITS-1:0] res_key,
    output logic [bhpq_pkg::PAY_BITS-1:0]     res_payload,
    output logic [bhpq_pkg::CNT_BITS-1:0]     res_fill
);

    localparam int AW = bhpq_pkg::ADDR_BITS;
    localparam int CW = bhpq_pkg::CNT_BITS;
    localparam int KW = bhpq_pkg::KEY_BITS;
    localparam int EW = bhpq_pkg::ENT_BITS;

    logic [CW-1:0] count_reg, count_next;
    logic          op_reg;
    logic [EW-1:0] mov_reg;      // entry being sifted {key, payload}
    logic [EW-1:0] top_reg;      // extracted root
    logic [CW-1:0] pos_reg;      // current hole position (wide: child math)
    logic          stop_reg;

    logic          we;
    logic [AW-1:0] waddr, addr_a, addr_b;
    logic [EW-1:0] wdata, rd_a, rd_b;

    logic [CW:0]   lchild, rchild;
    logic [CW-1:0] parent;
    logic [CW-1:0] last_idx;

    assign lchild   = {pos_reg, 1'b1};
    assign rchild   = {pos_reg, 1'b0} + {{CW{1'b0}}, 1'b1} + {{CW{1'b0}}, 1'b1};
    assign parent   = (pos_reg - {{(CW-1){1'b0}}, 1'b1}) >> 1;
    assign last_idx = count_reg - {{(CW-1){1'b0}}, 1'b1};

    bhpq_ram #(.WIDTH(EW), .DEPTH(bhpq_pkg::CAPACITY)) u_ram_a (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(addr_a), .rdata(rd_a)
    );
    bhpq_ram #(.WIDTH(EW), .DEPTH(bhpq_pkg::CAPACITY)) u_ram_b (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(addr_b), .rdata(rd_b)
    );

    // read addresses: a = root or parent or left child, b = last or right child
    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        if (cmd.dn_init)
        begin
            addr_a = '0;
            addr_b = last_idx[AW-1:0];
        end
        else if (op_reg == bhpq_pkg::OP_INSERT)
        begin
            addr_a = parent[AW-1:0];
        end
        else
        begin
            addr_a = lchild[AW-1:0];
            addr_b = rchild[AW-1:0];
        end
    end

    logic signed [KW-1:0] mov_key, a_key, b_key;
    logic l_ok, r_ok, l_win, r_win, pick_r, up_move, up_go;

    assign mov_key = mov_reg[EW-1 -: KW];
    assign a_key   = rd_a[EW-1 -: KW];
    assign b_key   = rd_b[EW-1 -: KW];
    assign l_ok    = ({1'b0, lchild} < {2'b0, count_reg});
    assign r_ok    = ({1'b0, rchild} < {2'b0, count_reg});
    assign l_win   = l_ok && bhpq_pkg::ranks_above(a_key, mov_key, max_mode);
    assign pick_r  = r_ok && (l_win ? bhpq_pkg::ranks_above(b_key, a_key, max_mode)
                                    : bhpq_pkg::ranks_above(b_key, mov_key, max_mode));
    assign r_win   = pick_r;
    assign up_move = bhpq_pkg::ranks_above(mov_key, a_key, max_mode);
    assign up_go   = (pos_reg != '0) && up_move;

    // write port: move parent/child into hole, or final placement
    always_comb
    begin
        we    = 1'b0;
        waddr = pos_reg[AW-1:0];
        wdata = mov_reg;
        if (cmd.up_step && up_go)
        begin
            we    = 1'b1;
            wdata = rd_a;
        end
        else if (cmd.dn_step && (l_win || r_win))
        begin
            we    = 1'b1;
            wdata = r_win ? rd_b : rd_a;
        end
        else if (cmd.done && !stop_reg)
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.up_init)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.dn_init)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            mov_reg  <= {in_key, in_payload};
            stop_reg <= 1'b0;
        end
        if (cmd.reject)
        begin
            stop_reg <= 1'b1;
        end
        if (cmd.up_init)
        begin
            pos_reg <= count_reg;
        end
        if (cmd.up_step && up_go)
        begin
            pos_reg <= parent;
        end
        if (cmd.dn_init)
        begin
            pos_reg <= '0;
        end
        if (cmd.dn_root)
        begin
            top_reg <= rd_a;
            mov_reg <= rd_b;
        end
        if (cmd.dn_step && (l_win || r_win))
        begin
            pos_reg <= r_win ? rchild[CW-1:0] : lchild[CW-1:0];
        end
        if (cmd.done)
        begin
            res_fill    <= count_reg;
            res_status  <= bhpq_pkg::ST_OK;
            res_key     <= '0;
            res_payload <= '0;
            if (stop_reg)
            begin
                res_status <= (op_reg == bhpq_pkg::OP_EXTRACT) ? bhpq_pkg::ST_EMPTY
                                                               : bhpq_pkg::ST_FULL;
            end
            else if (op_reg == bhpq_pkg::OP_EXTRACT)
            begin
                res_key     <= top_reg[EW-1 -: KW];
                res_payload <= top_reg[bhpq_pkg::PAY_BITS-1:0];
            end
        end
    end

    assign stat.is_extract = op_reg;
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CW'(bhpq_pkg::CAPACITY));
    assign stat.up_stop    = !up_go;
    assign stat.dn_stop    = !(l_win || r_win);

endmodule

[rtl/bhpq_ctrl.sv]
// ----------------------------------------------------------------------------
// bhpq_ctrl: operation sequencer and output word handshake
// ----------------------------------------------------------------------------
module bhpq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  bhpq_pkg::bhpq_stat_t stat,
    output bhpq_pkg::bhpq_cmd_t  cmd,
    output logic                 busy
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_UP    = 7'b0001000,
        S_DNRD  = 7'b0010000,
        S_DN    = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    // S_WAIT covers the registered RAM read after each position change (S_DNRD covers the first one on extract)
    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        ovalid_next = ovalid_reg && out_stall;
        in_stall    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = ovalid_reg && out_stall;
                if (in_valid && !in_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.is_extract ? stat.empty : stat.full)
                begin
                    cmd.reject = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.is_extract)
                begin
                    cmd.dn_init = 1'b1;
                    state_next  = S_DNRD;
                end
                else
                begin
                    cmd.up_init = 1'b1;
                    state_next  = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = stat.is_extract ? S_DN : S_UP;
            end
            S_UP:
            begin
                cmd.up_step = 1'b1;
                state_next  = stat.up_stop ? S_DONE : S_WAIT;
            end
            S_DNRD:
            begin
                // root and last entry back from ports a and b
                cmd.dn_root = 1'b1;
                state_next  = S_DN;
            end
            S_DN:
            begin
                cmd.dn_step = 1'b1;
                state_next  = stat.dn_stop ? S_DONE : S_WAIT;
            end
            S_DONE:
            begin
                if (!ovalid_reg)
                begin
                    cmd.done    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign busy      = (state_reg != S_IDLE);

endmodule

[verif/binary_heap_priority_queue_top_test.sv]
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_top_test: self-checking bench for the heap queue
// Pushes insert/extract words with random gaps against a stalling sink and
// checks each result word against a behavioral heap kept in the bench.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              op;
        logic signed [31:0] key;
        logic [31:0]       payload;
    } heap_cmd_t;

    typedef struct {
        logic [1:0]        status;
        logic signed [31:0] top_key;
        logic [31:0]       top_payload;
        logic [6:0]        fill;
    } heap_res_t;

    logic              clk;
    logic              rst_n;
    logic              valid;
    logic              stall;
    logic              op;
    logic signed [31:0] key;
    logic [31:0]       payload;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic signed [31:0] top_key;
    logic [31:0]       top_payload;
    logic [6:0]        fill;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;

    binary_heap_priority_queue_top DUT (
        .clk(clk), .rst_n(rst_n),
        .valid(valid), .stall(stall), .op(op), .key(key), .payload(payload),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .top_key(top_key), .top_payload(top_payload), .fill(fill),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // bench copy of the heap
    logic signed [31:0] heap_keys [bhpq_pkg::CAPACITY];
    logic [31:0]       heap_tags [bhpq_pkg::CAPACITY];
    int                heap_count;
    logic              order_max;

    heap_cmd_t pending_words[$];
    heap_res_t expected_words[$];

    int  mismatches;
    int  results_seen;
    int  inserts_sent;
    int  extracts_sent;
    int  full_hits;
    int  empty_hits;
    int  cycle_count;
    int  send_wait;
    int  sink_wait;
    bit  sink_hold;

    function automatic bit outranks(logic signed [31:0] a, logic signed [31:0] b);
        return order_max ? (a > b) : (a < b);
    endfunction

    function automatic heap_res_t heap_apply(heap_cmd_t c);
        heap_res_t r;
        int pos, par, l, rt, best;
        logic signed [31:0] tk;
        logic [31:0] tp;
        r = '{bhpq_pkg::ST_OK, 0, 0, 0};
        if (c.op == bhpq_pkg::OP_INSERT) begin
            if (heap_count >= bhpq_pkg::CAPACITY) begin
                r.status = bhpq_pkg::ST_FULL;
            end else begin
                pos = heap_count;
                heap_count++;
                while (pos >= 1) begin
                    par = (pos - 1) / 2;
                    if (!outranks(c.key, heap_keys[par])) break;
                    heap_keys[pos] = heap_keys[par];
                    heap_tags[pos] = heap_tags[par];
                    pos = par;
                end
                heap_keys[pos] = c.key;
                heap_tags[pos] = c.payload;
            end
        end else if (heap_count == 0) begin
            r.status = bhpq_pkg::ST_EMPTY;
        end else begin
            r.top_key = heap_keys[0];
            r.top_payload = heap_tags[0];
            heap_count--;
            heap_keys[0] = heap_keys[heap_count];
            heap_tags[0] = heap_tags[heap_count];
            pos = 0;
            forever begin
                l = 2 * pos + 1;
                rt = 2 * pos + 2;
                best = pos;
                if (l < heap_count && outranks(heap_keys[l], heap_keys[best])) best = l;
                if (rt < heap_count && outranks(heap_keys[rt], heap_keys[best])) best = rt;
                if (best == pos) break;
                tk = heap_keys[pos];
                tp = heap_tags[pos];
                heap_keys[pos] = heap_keys[best];
                heap_tags[pos] = heap_tags[best];
                heap_keys[best] = tk;
                heap_tags[best] = tp;
                pos = best;
            end
        end
        r.fill = heap_count[6:0];
        return r;
    endfunction

    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed($urandom_range(0, 7)) - 4;   // many ties
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic queue_word(logic o, logic signed [31:0] k, logic [31:0] p);
        heap_cmd_t c;
        c.op = o;
        c.key = k;
        c.payload = p;
        pending_words.push_back(c);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("binary_heap_priority_queue_top_test: done, errors");
                $finish;
            end
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid <= 1'b0;
            op <= 1'b0;
            key <= '0;
            payload <= '0;
            send_wait <= 0;
        end
        else if (valid && !stall)
        begin
            expected_words.push_back(heap_apply('{op, key, payload}));
            if (op == bhpq_pkg::OP_INSERT) inserts_sent++; else extracts_sent++;
            valid <= 1'b0;
            send_wait <= $urandom_range(0, 7);
        end
        else if (!valid)
        begin
            if (send_wait > 0)
                send_wait <= send_wait - 1;
            else if (pending_words.size() > 0)
            begin
                heap_cmd_t c;
                c = pending_words.pop_front();
                valid <= 1'b1;
                op <= c.op;
                key <= c.key;
                payload <= c.payload;
            end
        end
    end

    // sink stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_wait <= 0;
        end
        else if (sink_hold)
            out_stall <= 1'b1;
        else if (out_valid && !out_stall)
        begin
            sink_wait <= $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else if (sink_wait > 0)
        begin
            sink_wait <= sink_wait - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            heap_res_t e;
            results_seen++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d key %0d tag %h fill %0d",
                             status, top_key, top_payload, fill);
            end
            else
            begin
                e = expected_words.pop_front();
                if (e.status == bhpq_pkg::ST_FULL) full_hits++;
                if (e.status == bhpq_pkg::ST_EMPTY) empty_hits++;
                if (status !== e.status || top_key !== e.top_key ||
                    top_payload !== e.top_payload || fill !== e.fill)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: exp st %0d key %0d tag %h fill %0d, ",
                                  "got st %0d key %0d tag %h fill %0d"},
                                 results_seen, e.status, e.top_key, e.top_payload,
                                 e.fill, status, top_key, top_payload, fill);
                end
            end
        end
    end

    // checked at the falling edge, once all clocked updates have settled
    task automatic drain();
        while (pending_words.size() > 0 || valid || expected_words.size() > 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_order(logic m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        order_max = m;
    endtask

    // random bursts: inserts favoured below a depth of 40, extracts above it
    task automatic queue_phase(int words);
        int n;
        int depth;
        n = 0;
        depth = 0;
        while (n < words)
        begin
            if ($urandom_range(0, 99) < (depth < 40 ? 60 : 40))
            begin
                queue_word(bhpq_pkg::OP_INSERT, rand_key(), $urandom);
                depth = depth < bhpq_pkg::CAPACITY ? depth + 1 : depth;
            end
            else
            begin
                queue_word(bhpq_pkg::OP_EXTRACT, $signed($urandom), $urandom);
                depth = depth > 0 ? depth - 1 : 0;
            end
            n++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b1;
        sink_hold = 1'b0;
        order_max = 1'b1;
        heap_count = 0;
        mismatches = 0;
        results_seen = 0;
        inserts_sent = 0;
        extracts_sent = 0;
        full_hits = 0;
        empty_hits = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset order (max): empty extract, extremes, ties
        queue_word(bhpq_pkg::OP_EXTRACT, 0, 0);
        queue_word(bhpq_pkg::OP_INSERT, 32'sh8000_0000, 32'h0000_0000);
        queue_word(bhpq_pkg::OP_INSERT, 32'sh7fff_ffff, 32'hffff_ffff);
        queue_word(bhpq_pkg::OP_INSERT, 5, 32'haaaa_aaaa);
        queue_word(bhpq_pkg::OP_INSERT, 5, 32'h5555_5555);
        queue_word(bhpq_pkg::OP_INSERT, 0, 32'h1234_5678);
        queue_word(bhpq_pkg::OP_INSERT, -1, 32'h8765_4321);
        repeat (7) queue_word(bhpq_pkg::OP_EXTRACT, 0, 0);
        drain();

        // fill to capacity and overflow in min order, then extract until empty
        write_order(1'b0);
        for (int i = 0; i < bhpq_pkg::CAPACITY + 2; i++)
            queue_word(bhpq_pkg::OP_INSERT, rand_key(), $urandom);
        // mode flip with entries held is covered below
        drain();
        write_order(1'b1);
        for (int i = 0; i < 30; i++)
            queue_word(bhpq_pkg::OP_EXTRACT, 0, 0);
        queue_word(bhpq_pkg::OP_INSERT, 32'sh7fff_ffff, 32'h0);
        drain();
        write_order(1'b0);
        for (int i = 0; i < bhpq_pkg::CAPACITY + 2; i++)
            queue_word(bhpq_pkg::OP_EXTRACT, 0, 0);
        drain();

        // random phases over both orders, with a long sink hold in one
        for (int ph = 0; ph < 6; ph++)
        begin
            write_order(ph[0]);
            queue_phase(100);
            if (ph == 2)
            begin
                sink_hold = 1'b1;
                repeat (300) @(posedge clk);
                sink_hold = 1'b0;
            end
            drain();
        end

        $display("%0d inserts, %0d extracts, %0d results; full hits %0d, empty hits %0d",
                 inserts_sent, extracts_sent, results_seen, full_hits, empty_hits);
        if (mismatches == 0)
            $display("binary_heap_priority_queue_top_test: done, clean");
        else
            $display("binary_heap_priority_queue_top_test: done, errors");
        $finish;
    end

endmodule
